@@ sv/ect_pkg.sv @@
// Shared types and constants for the edge coverage tracker.
// No dependencies.
package ect_pkg;

  localparam int unsigned CfgW   = 17;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CountW = 8;

  localparam logic CFG_MAP_LIMIT  = 1'b0;
  localparam logic CFG_COND_COUNT = 1'b1;

  localparam logic REQ_COND     = 1'b0;
  localparam logic REQ_INDIRECT = 1'b1;

  localparam logic [CfgW-1:0] MAP_LIMIT_RST  = 17'd65536;
  localparam logic [CfgW-1:0] COND_COUNT_RST = 17'd32768;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_ASSIGN = 6'b001000,
    ST_CREAD  = 6'b010000,
    ST_CWRITE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic [IdW-1:0]   id;
  } entry_t;

endpackage

@@ sv/ect_edge_table.sv @@
// Edge table storage: key pair and assigned id per entry.
// One write port, one read port with registered data. Uses ect_pkg.
module ect_edge_table import ect_pkg::*; #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ect_count_ram.sv @@
// Hit counter store, 8 bits per slot.
// One write port, one read port with registered data. Uses ect_pkg.
module ect_count_ram import ect_pkg::*; #(
  parameter int unsigned Slots = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CountW-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CountW-1:0] rdata_o
);

  logic [CountW-1:0] mem [Slots];
  logic [CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/edge_coverage_tracker.sv @@
// Edge coverage tracker: 8-bit hit counters plus an indirect edge table.
// Channels: request in (in_valid_i / in_stall_o), result out (out_valid_o / out_stall_i).
// A request is taken when valid is high and stall low; one result per request.
// Conditional request: after accept the counter is read (ST_CREAD), then written back
// (ST_CWRITE) as the result register is loaded; the next one is taken in ST_IDLE.
// Indirect request: the table is scanned linearly over the filled entries, one entry
// per cycle through the table read port, until a hit or the end of the filled entries.
// One request is in flight at a time; the next is taken once the result is registered,
// even while the receiver still stalls it.
// Reset: control state clears at once, then a clearing pass zeroes the counter store,
// one slot per cycle, with in_stall_o high. Config writes are taken meanwhile. Entries
// of the edge table are tracked by a fill count.
// A stalled result holds in the output register; the core waits for it to drain
// before writing the next one. MAP_SLOTS must be a power of two.
// Uses ect_pkg, ect_edge_table, ect_count_ram.
module edge_coverage_tracker import ect_pkg::*; #(
  parameter int unsigned MAP_SLOTS        = 65536,
  parameter int unsigned EDGE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [IdW-1:0]    cond_index_i,
  input  logic [AddrW-1:0]  src_address_i,
  input  logic [AddrW-1:0]  dest_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IdW-1:0]    edge_id_o,
  output logic [CountW-1:0] hit_count_o,
  output logic              was_new_o,
  output logic              table_full_o,
  output logic              new_edge_seen_o
);

  localparam int unsigned CW = $clog2(MAP_SLOTS);
  localparam int unsigned TW = $clog2(EDGE_TABLE_DEPTH);
  localparam int unsigned FW = $clog2(EDGE_TABLE_DEPTH + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(EDGE_TABLE_DEPTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(MAP_SLOTS - 1);
  localparam logic [20:0] SLOT_CAP = 21'((MAP_SLOTS < 65536) ? MAP_SLOTS : 65536);
  // conditional index wraps at the store size
  localparam logic [IdW-1:0] ID_MASK = (MAP_SLOTS >= 65536) ? '1 : IdW'(MAP_SLOTS - 1);

  state_e state_q, state_d;

  logic [CfgW-1:0] map_limit_q, cond_count_q;
  logic [FW-1:0]   fill_q;
  logic [FW-1:0]   scan_q;
  logic            pend_q;
  logic [IdW-1:0]  last_id_q;
  logic            flag_q;
  logic [CW-1:0]   clr_q;

  logic             type_q;
  logic [AddrW-1:0] src_q, dst_q;
  logic [IdW-1:0]   id_q;
  logic             new_q, full_q;

  logic              out_valid_q;
  logic [IdW-1:0]    out_id_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_new_q, out_full_q, out_seen_q;

  entry_t            tbl_rdata, tbl_wdata;
  logic              tbl_we, tbl_re;
  logic [CountW-1:0] cnt_rdata;
  logic              cnt_we, cnt_re;
  logic [CW-1:0]     cnt_waddr, cnt_raddr;
  logic [CountW-1:0] cnt_wdata;

  logic        in_acc, out_free, hit, scan_done;
  logic [31:0] id_ext;
  logic [20:0] lim, floor_id, base, nxt;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hit       = pend_q && (tbl_rdata.src == src_q) && (tbl_rdata.dst == dst_q);
  assign scan_done = (scan_q == fill_q);
  assign id_ext    = {16'd0, id_q};

  // New id: raise to floor, step, saturate at the effective limit
  always_comb begin
    lim = (map_limit_q == '0) ? 21'd1 : {4'd0, map_limit_q};
    if (lim > SLOT_CAP) lim = SLOT_CAP;
    floor_id = (cond_count_q == '0) ? 21'd0 : ({4'd0, cond_count_q} - 21'd1);
    base = ({5'd0, last_id_q} < floor_id) ? floor_id : {5'd0, last_id_q};
    nxt = base + 21'd1;
    if (nxt >= lim) nxt = lim - 21'd1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = (req_type_i == REQ_INDIRECT) ? ST_SCAN : ST_CREAD;
      ST_SCAN: begin
        if (hit) state_d = ST_CREAD;
        else if (scan_done) state_d = ST_ASSIGN;
      end
      ST_ASSIGN: state_d = ST_CREAD;
      ST_CREAD:  state_d = ST_CWRITE;
      ST_CWRITE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign tbl_re    = (state_q == ST_SCAN) && !scan_done && !hit;
  assign tbl_we    = (state_q == ST_ASSIGN) && (fill_q != FILL_MAX);
  assign tbl_wdata = '{src: src_q, dst: dst_q, id: nxt[IdW-1:0]};

  assign cnt_re    = (state_q == ST_CREAD);
  assign cnt_raddr = id_ext[CW-1:0];
  assign cnt_we    = (state_q == ST_CLEAR) || ((state_q == ST_CWRITE) && out_free);
  assign cnt_waddr = (state_q == ST_CLEAR) ? clr_q : id_ext[CW-1:0];
  assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_rdata + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      map_limit_q  <= MAP_LIMIT_RST;
      cond_count_q <= COND_COUNT_RST;
      fill_q       <= '0;
      scan_q       <= '0;
      pend_q       <= 1'b0;
      last_id_q    <= '0;
      flag_q       <= 1'b0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAP_LIMIT) map_limit_q <= cfg_data_i;
        else map_limit_q <= map_limit_q;
        if (cfg_index_i == CFG_COND_COUNT) cond_count_q <= cfg_data_i;
        else cond_count_q <= cond_count_q;
      end
      if (state_q == ST_CLEAR) clr_q <= clr_q + CW'(1);
      if (in_acc) begin
        scan_q <= '0;
        pend_q <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        pend_q <= tbl_re;
        if (tbl_re) scan_q <= scan_q + FW'(1);
      end
      if (state_q == ST_ASSIGN) begin
        last_id_q <= nxt[IdW-1:0];
        flag_q    <= 1'b1;
        if (tbl_we) fill_q <= fill_q + FW'(1);
      end
      if ((state_q == ST_CWRITE) && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Request payload and result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      type_q <= req_type_i;
      src_q  <= src_address_i;
      dst_q  <= dest_address_i;
      id_q   <= cond_index_i & ID_MASK;
      new_q  <= 1'b0;
      full_q <= 1'b0;
    end
    if ((state_q == ST_SCAN) && hit) id_q <= tbl_rdata.id;
    if (state_q == ST_ASSIGN) begin
      id_q   <= nxt[IdW-1:0];
      new_q  <= 1'b1;
      full_q <= !tbl_we;
    end
    if ((state_q == ST_CWRITE) && out_free) begin
      out_id_q   <= id_q;
      out_cnt_q  <= cnt_wdata;
      out_new_q  <= new_q && (type_q == REQ_INDIRECT);
      out_full_q <= full_q && (type_q == REQ_INDIRECT);
      out_seen_q <= flag_q;
    end
  end

  ect_edge_table #(.Depth(EDGE_TABLE_DEPTH), .AW(TW)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (fill_q[TW-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (scan_q[TW-1:0]),
    .rdata_o (tbl_rdata)
  );

  ect_count_ram #(.Slots(MAP_SLOTS), .AW(CW)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign edge_id_o       = out_id_q;
  assign hit_count_o     = out_cnt_q;
  assign was_new_o       = out_new_q;
  assign table_full_o    = out_full_q;
  assign new_edge_seen_o = out_seen_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX) else $error("fill count past table depth");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= fill_q) else $error("scan index past fill count");
  a_full_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> was_new_o && new_edge_seen_o)
    else $error("table full without new edge");
  a_no_req_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q) else $error("result during clear");
`endif

endmodule

@@ dv/edge_coverage_checker.sv @@
`timescale 1ns / 1ps
// Checker for the edge coverage tracker: watches the config port and both channels,
// predicts every result from its own copy of the counters and edge table, and compares.
// Uses ect_pkg.
module edge_coverage_checker import ect_pkg::*; #(
  parameter int unsigned MAP_SLOTS        = 65536,
  parameter int unsigned EDGE_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              req_type_i,
  input  logic [IdW-1:0]    cond_index_i,
  input  logic [AddrW-1:0]  src_address_i,
  input  logic [AddrW-1:0]  dest_address_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [IdW-1:0]    edge_id_i,
  input  logic [CountW-1:0] hit_count_i,
  input  logic              was_new_i,
  input  logic              table_full_i,
  input  logic              new_edge_seen_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CountW-1:0] count;
    logic              was_new;
    logic              full;
    logic              seen;
  } coverage_result_t;

  logic [CountW-1:0] hit_counts [MAP_SLOTS];
  logic [AddrW-1:0]  key_src [EDGE_TABLE_DEPTH];
  logic [AddrW-1:0]  key_dst [EDGE_TABLE_DEPTH];
  logic [IdW-1:0]    key_id [EDGE_TABLE_DEPTH];
  int unsigned       fill;
  int unsigned       last_id;
  logic              seen_flag;
  logic [CfgW-1:0]   map_limit;
  logic [CfgW-1:0]   cond_count;
  coverage_result_t  expected_results [$];

  function automatic coverage_result_t record_hit(input logic kind, input logic [IdW-1:0] cidx,
                                                  input logic [AddrW-1:0] src,
                                                  input logic [AddrW-1:0] dst);
    coverage_result_t r;
    int unsigned lim;
    int unsigned floor_id;
    int unsigned nxt;
    int unsigned slot;
    bit found;
    r = '0;
    found = 1'b0;
    if (kind == REQ_COND) begin
      slot = cidx % MAP_SLOTS;
    end else begin
      for (int i = 0; i < fill; i++) begin
        if (!found && key_src[i] == src && key_dst[i] == dst) begin
          found = 1'b1;
          slot = key_id[i];
        end
      end
      if (!found) begin
        lim = (map_limit == 0) ? 1 : map_limit;
        if (lim > MAP_SLOTS) lim = MAP_SLOTS;
        if (lim > 65536) lim = 65536;
        floor_id = ((cond_count == 0) ? 1 : cond_count) - 1;
        nxt = (last_id < floor_id) ? floor_id : last_id;
        nxt++;
        if (nxt >= lim) nxt = lim - 1;
        last_id = nxt;
        seen_flag = 1'b1;
        r.was_new = 1'b1;
        if (fill < EDGE_TABLE_DEPTH) begin
          key_src[fill] = src;
          key_dst[fill] = dst;
          key_id[fill] = nxt[IdW-1:0];
          fill++;
        end else begin
          r.full = 1'b1;
        end
        slot = nxt;
      end
      slot = slot % MAP_SLOTS;
    end
    hit_counts[slot] = hit_counts[slot] + 1'b1;
    r.id = slot[IdW-1:0];
    r.count = hit_counts[slot];
    r.seen = seen_flag;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coverage_result_t got;
    coverage_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAP_SLOTS; i++) hit_counts[i] = '0;
      fill = 0;
      last_id = 0;
      seen_flag = 1'b0;
      map_limit = MAP_LIMIT_RST;
      cond_count = COND_COUNT_RST;
      fail_count_o = 0;
      checked_o = 0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MAP_LIMIT) map_limit = cfg_data_i;
        else cond_count = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(record_hit(req_type_i, cond_index_i, src_address_i,
                                              dest_address_i));
      if (out_valid_i && !out_stall_i) begin
        got = '{edge_id_i, hit_count_i, was_new_i, table_full_i, new_edge_seen_i};
        checked_o++;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

@@ dv/edge_coverage_tracker_test.sv @@
`timescale 1ns / 1ps
// Testbench top for edge_coverage_tracker: clock, reset, request and config stimulus,
// result-side stalls, verdict. Uses ect_pkg and edge_coverage_checker.
module edge_coverage_tracker_test;
  import ect_pkg::*;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned TableDepth = 1024;

  typedef struct packed {
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
  } edge_pair_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [CfgW-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              req_type_i;
  logic [IdW-1:0]    cond_index_i;
  logic [AddrW-1:0]  src_address_i;
  logic [AddrW-1:0]  dest_address_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IdW-1:0]    edge_id_o;
  logic [CountW-1:0] hit_count_o;
  logic              was_new_o;
  logic              table_full_o;
  logic              new_edge_seen_o;

  int unsigned fail_count;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned n_sent;
  bit          calm;
  bit          hold_go;
  bit          hold_done;
  int unsigned hold_left;
  edge_pair_t  known_pairs [$];

  edge_coverage_tracker i_dut (.*);

  edge_coverage_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .cond_index_i,
    .src_address_i, .dest_address_i,
    .out_valid_i(out_valid_o), .out_stall_i, .edge_id_i(edge_id_o),
    .hit_count_i(hit_count_o), .was_new_i(was_new_o), .table_full_i(table_full_o),
    .new_edge_seen_i(new_edge_seen_o),
    .fail_count_o(fail_count), .pending_o(n_pending), .checked_o(n_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("edge_coverage_tracker_test failed");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin
    out_stall_i = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 8);
    end
  end

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_request(input logic kind, input logic [IdW-1:0] cidx,
                              input edge_pair_t pair);
    bit stalled;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    cond_index_i <= cidx;
    src_address_i <= pair.src;
    dest_address_i <= pair.dst;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    n_sent++;
  endtask

  task automatic send_cond(input logic [IdW-1:0] cidx);
    send_request(REQ_COND, cidx, {$urandom, $urandom, $urandom, $urandom});
  endtask

  task automatic send_edge(input edge_pair_t pair);
    send_request(REQ_INDIRECT, IdW'($urandom), pair);
  endtask

  task automatic send_fresh_edge();
    edge_pair_t p;
    p = {$urandom, $urandom, $urandom, $urandom};
    known_pairs.push_back(p);
    send_edge(p);
  endtask

  task automatic drain_and_configure(input logic [CfgW-1:0] limit,
                                     input logic [CfgW-1:0] cond);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MAP_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_index_i <= CFG_COND_COUNT;
    cfg_data_i <= cond;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    edge_pair_t p;
    int unsigned pick;
    pick = $urandom_range(99);
    if ($urandom_range(1)) begin
      send_cond(($urandom_range(99) < 60) ? IdW'($urandom_range(1)) : IdW'($urandom));
    end else if (known_pairs.size() != 0 && pick < 50) begin
      send_edge(known_pairs[$urandom_range(known_pairs.size() - 1)]);
    end else if (known_pairs.size() != 0 && pick < 60) begin
      // near miss: one half of a known pair, the other half new
      p = known_pairs[$urandom_range(known_pairs.size() - 1)];
      if ($urandom_range(1)) p.src = {$urandom, $urandom};
      else p.dst = {$urandom, $urandom};
      known_pairs.push_back(p);
      send_edge(p);
    end else begin
      send_fresh_edge();
    end
  endtask

  initial begin
    logic [CfgW-1:0] limits [5];
    logic [CfgW-1:0] conds [5];
    limits = '{17'd65536, 17'd65536, 17'd300, 17'd65536, 17'd2};
    conds  = '{17'd32768, 17'd1, 17'd200, 17'd65536, 17'd1};
    n_sent = 0;
    calm = 1'b0;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MAP_LIMIT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_COND;
    cond_index_i = '0;
    src_address_i = '0;
    dest_address_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, hits, near misses, id floor and saturation
    drain_and_configure(17'd65536, 17'd32768);
    send_cond('0);
    send_cond('1);
    send_cond('0);
    send_cond(16'h5555);
    send_cond(16'haaaa);
    known_pairs.push_back('0);
    send_edge('0);
    known_pairs.push_back('1);
    send_edge('1);
    send_edge('0);
    send_edge({64'h0, 64'hffff_ffff_ffff_ffff});
    send_edge({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
    drain_and_configure(17'd65536, 17'd1);
    send_fresh_edge();
    send_edge('1);
    drain_and_configure(17'd1, 17'd65536);
    send_fresh_edge();
    send_fresh_edge();
    drain_and_configure(17'd65536, 17'd65536);
    send_fresh_edge();
    send_fresh_edge();
    send_cond(16'hffff);
    drain_and_configure(17'd40, 17'd30);
    send_fresh_edge();
    send_fresh_edge();

    // random phases, one setting each; one phase runs with no idling
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_configure(limits[ph], conds[ph]);
      calm = (ph == 3);
      for (int k = 0; k < 110; k++) begin
        if (ph == 1 && k == 20) hold_go <= 1'b1;
        random_request();
      end
    end

    // fill the table past its depth; all new ids pile onto slot 0, so it wraps
    drain_and_configure(17'd1, 17'd65536);
    calm = 1'b1;
    while (known_pairs.size() < TableDepth + 8) send_fresh_edge();
    send_edge(known_pairs[0]);
    send_edge(known_pairs[known_pairs.size() - 1]);
    calm = 1'b0;
    for (int k = 0; k < 6; k++) random_request();

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    repeat (1200) @(posedge clk_i);
    $display("%0d requests sent, %0d results checked, %0d distinct edges offered",
             n_sent, n_checked, known_pairs.size());
    $display("covered conditional and indirect hits, id floor and saturation, full table");
    if (fail_count == 0 && n_pending == 0) begin
      $display("edge_coverage_tracker_test passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("edge_coverage_tracker_test failed");
    end
    $finish;
  end

endmodule
